/* rtl/pdt_pkg.sv */
// Package: shared constants, payload structs and controller types for the deadline timer table.
`default_nettype none

package pdt_pkg;

  // Default sizing and fixed constants
  localparam int unsigned SLOTS_DEF     = 4;
  localparam int unsigned ID_BITS_DEF   = 16;
  localparam int unsigned US_PER_MS     = 1000;
  localparam logic [31:0] HICCUP_RESET  = 32'd10000000;
  localparam int unsigned PERIOD_US_W   = 42;

  // Command codes of an input beat
  localparam logic CMD_REGISTER = 1'b0;
  localparam logic CMD_TICK     = 1'b1;

  // Status codes of a result beat
  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_FULL = 1'b1;

  // Input beat
  typedef struct packed {
    logic        command;
    logic [15:0] client_id;
    logic [31:0] period_ms;
    logic [63:0] now_us;
  } pdt_in_t;

  // Result beat
  typedef struct packed {
    logic        fired;
    logic [15:0] fired_id;
    logic [1:0]  fired_slot;
    logic        status;
    logic [31:0] tick_count;
    logic [31:0] call_count;
    logic        last;
  } pdt_out_t;

  // Controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_REG_MUL,
    ST_REG_WR,
    ST_SCAN,
    ST_CLOSE
  } pdt_state_e;

  // Controller to datapath commands
  typedef struct packed {
    logic load;
    logic mul;
    logic reg_write;
    logic scan;
    logic close;
  } pdt_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic started;
    logic scan_last;
  } pdt_stat_t;

endpackage

`default_nettype wire

/* rtl/periodic_deadline_timer_table.sv */
// Top level: periodic deadline timer table, controller plus datapath.
//
// A beat is taken when start is high and busy is low. A register command keeps busy
// high through ST_REG_MUL, which forms period_ms * 1000, and ST_REG_WR, which searches
// the table, writes the slot and registers the closing result. A tick before the first
// registration at a nonzero time goes straight to ST_CLOSE. Any other tick scans in
// ST_SCAN, then closes: the scan checks one slot per cycle through a single 64-bit
// compare-and-advance unit, issues a fired result in the cycle after each due slot,
// and ends with the closing result that carries the counters. Results appear on res_o
// for one cycle each, marked by res_valid_o, and the receiver cannot hold them off. The
// user must write hiccup_threshold_us through cfg_we_i and cfg_wdata_i only while the
// block is idle; the block does not enforce this. It resets to 10000000.
`default_nettype none

module periodic_deadline_timer_table #(
  parameter int unsigned SLOTS   = pdt_pkg::SLOTS_DEF,
  parameter int unsigned ID_BITS = pdt_pkg::ID_BITS_DEF
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start,
  output logic                   busy,
  input  wire pdt_pkg::pdt_in_t  in_i,
  input  wire logic              cfg_we_i,
  input  wire logic [31:0]       cfg_wdata_i,
  output logic                   res_valid_o,
  output pdt_pkg::pdt_out_t      res_o
);
  import pdt_pkg::*;

  pdt_cmd_t  cmd;
  pdt_stat_t stat;

  // Sequence each beat
  pdt_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start     (start),
    .command_i (in_i.command),
    .stat_i    (stat),
    .cmd_o     (cmd),
    .busy      (busy)
  );

  // Hold the table and form results
  pdt_datapath #(
    .SLOTS   (SLOTS),
    .ID_BITS (ID_BITS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .res_valid_o (res_valid_o),
    .res_o       (res_o)
  );

endmodule

`default_nettype wire

/* rtl/pdt_ctrl.sv */
// Controller: state machine that sequences registration, slot scan and closing beats.
`default_nettype none

module pdt_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start,
  input  wire logic              command_i,
  input  wire pdt_pkg::pdt_stat_t stat_i,
  output pdt_pkg::pdt_cmd_t      cmd_o,
  output logic                   busy
);
  import pdt_pkg::*;

  pdt_state_e state_q, state_d;

  // Hold state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Pick next state and drive datapath commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    busy    = 1'b1;
    case (state_q)
      ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd_o.load = 1'b1;
          if (command_i == CMD_REGISTER) begin
            state_d = ST_REG_MUL;
          end else if (stat_i.started) begin
            state_d = ST_SCAN;
          end else begin
            state_d = ST_CLOSE;
          end
        end
      end
      ST_REG_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = ST_REG_WR;
      end
      ST_REG_WR: begin
        cmd_o.reg_write = 1'b1;
        state_d         = ST_IDLE;
      end
      ST_SCAN: begin
        cmd_o.scan = 1'b1;
        if (stat_i.scan_last) begin
          state_d = ST_CLOSE;
        end
      end
      ST_CLOSE: begin
        cmd_o.close = 1'b1;
        state_d     = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

/* rtl/pdt_datapath.sv */
// Datapath: slot table, counters, threshold register and result register.
`default_nettype none

module pdt_datapath #(
  parameter int unsigned SLOTS   = pdt_pkg::SLOTS_DEF,
  parameter int unsigned ID_BITS = pdt_pkg::ID_BITS_DEF
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire pdt_pkg::pdt_in_t   in_i,
  input  wire logic               cfg_we_i,
  input  wire logic [31:0]        cfg_wdata_i,
  input  wire pdt_pkg::pdt_cmd_t  cmd_i,
  output pdt_pkg::pdt_stat_t      stat_o,
  output logic                    res_valid_o,
  output pdt_pkg::pdt_out_t       res_o
);
  import pdt_pkg::*;

  localparam int unsigned SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam logic [SLOT_W-1:0] LAST_IDX = SLOT_W'(SLOTS - 1);

  // Latched input beat and control registers
  pdt_in_t     item_q;
  logic [31:0] thr_q;
  logic [31:0] ticks_q;
  logic [31:0] calls_q;
  logic        started_q;
  logic [SLOT_W-1:0] idx_q;
  logic [PERIOD_US_W-1:0] period_us_q;

  // Slot table
  logic                   valid_q    [SLOTS];
  logic [ID_BITS-1:0]     client_q   [SLOTS];
  logic [PERIOD_US_W-1:0] period_q   [SLOTS];
  logic [63:0]            deadline_q [SLOTS];

  // Result register
  logic     out_valid_q, out_valid_d;
  pdt_out_t out_q, out_d;

  // Id of the item, held to ID_BITS
  logic [ID_BITS+15:0] id_wide;
  logic [ID_BITS-1:0]  id_m;
  assign id_wide = {{ID_BITS{1'b0}}, item_q.client_id};
  assign id_m    = id_wide[ID_BITS-1:0];

  // Find the slot that holds this id and the first free slot
  logic              hit_found, free_found;
  logic [SLOT_W-1:0] hit_idx, free_idx, w_idx;
  logic              per_zero, reg_set, reg_clr, reg_full;

  always_comb begin
    hit_found  = 1'b0;
    free_found = 1'b0;
    hit_idx    = '0;
    free_idx   = '0;
    for (int i = 0; i < SLOTS; i++) begin
      if (!hit_found && valid_q[i] && (client_q[i] == id_m)) begin
        hit_found = 1'b1;
        hit_idx   = SLOT_W'(i);
      end
      if (!free_found && !valid_q[i]) begin
        free_found = 1'b1;
        free_idx   = SLOT_W'(i);
      end
    end
  end

  assign per_zero = (item_q.period_ms == 32'd0);
  assign w_idx    = hit_found ? hit_idx : free_idx;
  assign reg_set  = cmd_i.reg_write && !per_zero && (hit_found || free_found);
  assign reg_clr  = cmd_i.reg_write && per_zero && hit_found;
  assign reg_full = !per_zero && !hit_found && !free_found;

  // Check the slot under the scan index
  logic [63:0] s_dl, s_diff, dl_rebase, dl_step, dl_new;
  logic [63:0] s_per;
  logic        s_due, s_late, fire;

  assign s_dl      = deadline_q[idx_q];
  assign s_per     = {{(64 - PERIOD_US_W){1'b0}}, period_q[idx_q]};
  assign s_due     = valid_q[idx_q] && (item_q.now_us >= s_dl);
  assign s_diff    = item_q.now_us - s_dl;
  assign s_late    = s_diff > {32'd0, thr_q};
  assign dl_rebase = item_q.now_us + s_per;
  assign dl_step   = s_dl + s_per;
  assign dl_new    = s_late ? dl_rebase : dl_step;
  assign fire      = cmd_i.scan && s_due;

  // Fired id and slot cut to the result widths
  logic [ID_BITS+15:0] fid_wide;
  logic [SLOT_W+1:0]   fslot_wide;
  assign fid_wide   = {16'd0, client_q[idx_q]};
  assign fslot_wide = {2'b00, idx_q};

  // Form the next result beat
  always_comb begin
    out_valid_d = 1'b0;
    out_d       = out_q;
    if (cmd_i.reg_write) begin
      out_valid_d      = 1'b1;
      out_d            = '0;
      out_d.status     = reg_full ? STATUS_FULL : STATUS_OK;
      out_d.tick_count = ticks_q;
      out_d.call_count = calls_q;
      out_d.last       = 1'b1;
    end else if (cmd_i.close) begin
      out_valid_d      = 1'b1;
      out_d            = '0;
      out_d.status     = STATUS_OK;
      out_d.tick_count = ticks_q;
      out_d.call_count = calls_q;
      out_d.last       = 1'b1;
    end else if (fire) begin
      out_valid_d      = 1'b1;
      out_d            = '0;
      out_d.fired      = 1'b1;
      out_d.fired_id   = fid_wide[15:0];
      out_d.fired_slot = fslot_wide[1:0];
      out_d.status     = STATUS_OK;
      out_d.tick_count = ticks_q;
      out_d.call_count = calls_q + 32'd1;
      out_d.last       = 1'b0;
    end
  end

  // Control registers, counters and valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q       <= HICCUP_RESET;
      ticks_q     <= '0;
      calls_q     <= '0;
      started_q   <= 1'b0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < SLOTS; i++) begin
        valid_q[i] <= 1'b0;
      end
    end else begin
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        thr_q <= cfg_wdata_i;
      end
      if (cmd_i.load) begin
        idx_q <= '0;
        if (in_i.command == CMD_TICK && started_q) begin
          ticks_q <= ticks_q + 32'd1;
        end
      end
      if (cmd_i.scan && idx_q != LAST_IDX) begin
        idx_q <= idx_q + SLOT_W'(1);
      end
      if (fire) begin
        calls_q <= calls_q + 32'd1;
      end
      if (reg_set) begin
        valid_q[w_idx] <= 1'b1;
        if (item_q.now_us != 64'd0) begin
          started_q <= 1'b1;
        end
      end
      if (reg_clr) begin
        valid_q[hit_idx] <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    out_q <= out_d;
    if (cmd_i.load) begin
      item_q <= in_i;
    end
    if (cmd_i.mul) begin
      period_us_q <= {10'd0, item_q.period_ms} * PERIOD_US_W'(US_PER_MS);
    end
    if (reg_set) begin
      client_q[w_idx]   <= id_m;
      period_q[w_idx]   <= period_us_q;
      deadline_q[w_idx] <= item_q.now_us + {{(64 - PERIOD_US_W){1'b0}}, period_us_q};
    end
    if (fire) begin
      deadline_q[idx_q] <= dl_new;
    end
  end

  assign stat_o.started   = started_q;
  assign stat_o.scan_last = (idx_q == LAST_IDX);
  assign res_valid_o      = out_valid_q;
  assign res_o            = out_q;

endmodule

`default_nettype wire

/* rtl/pdt_checker.sv */
// Checker: port-level assertions for the deadline timer table, with its bind.
`default_nettype none

module pdt_checker (
  input wire logic              clk_i,
  input wire logic              rst_ni,
  input wire logic              start,
  input wire logic              busy,
  input wire logic              res_valid_o,
  input wire pdt_pkg::pdt_out_t res_o
);
  import pdt_pkg::*;

  // An accepted beat makes the block busy
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("busy not raised after an accepted beat");

  // A closing beat shows only once the block is free again
  a_last_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && res_o.last) |-> !busy)
    else $error("closing beat while busy");

  // Every beat before the closing one reports a fired client with ok status
  a_fired_form: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && !res_o.last) |-> (res_o.fired && (res_o.status == STATUS_OK)))
    else $error("non-closing beat is not a fired report");

  // No result appears unless the block was working in the cycle before
  a_no_invented: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> $past(busy))
    else $error("result beat without work in progress");

endmodule

bind periodic_deadline_timer_table pdt_checker u_pdt_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .start       (start),
  .busy        (busy),
  .res_valid_o (res_valid_o),
  .res_o       (res_o)
);

`default_nettype wire
